// ===== rtl/gsu_pkg.sv =====
package gsu_pkg;

  // Widths of the input coordinates, the shared multiplier operands, the
  // product, the accumulator and the search direction.
  localparam int PT_W   = 16;
  localparam int OP_W   = 36;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int DIR_W  = 57;

  // Vector registers that the shared unit reads and writes.
  typedef enum logic [3:0] {
    V_A,
    V_B,
    V_C,
    V_D,
    V_AB,
    V_AC,
    V_AD,
    V_AO,
    V_ABC,
    V_T,
    V_DIR
  } vsel_e;

  // One issued multiply-accumulate step.
  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       neg;
    logic       wr;
    logic       dot;
    logic [1:0] comp;
    vsel_e      dest;
  } mac_ctrl_t;

  // Write-back from the accumulator stage.
  typedef struct packed {
    logic                     wr;
    logic                     dot;
    logic [1:0]               comp;
    vsel_e                    dest;
    logic signed [ACC_W-1:0]  val;
  } mac_wb_t;

endpackage

// ===== rtl/gsu_mac.sv =====
module gsu_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gsu_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [gsu_pkg::OP_W-1:0]    op_a_i,
  input  logic signed [gsu_pkg::OP_W-1:0]    op_b_i,
  output gsu_pkg::mac_wb_t                   wb_o
);

  localparam int AccW  = gsu_pkg::ACC_W;
  localparam int ProdW = gsu_pkg::PROD_W;

  gsu_pkg::mac_ctrl_t      ctrl_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  // The product is registered before it reaches the accumulator.
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
    if (ctrl_q.vld) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    addend = ctrl_q.neg ? -AccW'(prod_q) : AccW'(prod_q);
    acc_d  = (ctrl_q.clr ? '0 : acc_q) + addend;
  end

  assign wb_o.wr   = ctrl_q.vld & ctrl_q.wr;
  assign wb_o.dot  = ctrl_q.vld & ctrl_q.dot;
  assign wb_o.comp = ctrl_q.comp;
  assign wb_o.dest = ctrl_q.dest;
  assign wb_o.val  = acc_d;

endmodule

// ===== rtl/gjk_simplex_update.sv =====
// One step of the GJK simplex update. Each transfer on the input channel
// (in_valid_i high, in_stall_o low) brings a new support point, which becomes
// vertex A and is combined with the stored vertices B, C and D. The block
// reduces the simplex, works out the next search direction exactly and flags
// when the origin is enclosed. Every input transfer gives exactly one result
// transfer on the output channel (out_valid_o high, out_stall_i low).
// All cross and dot products run on one shared multiply-accumulate unit under
// a small sequencer, one product per cycle, with a drain state and a decide
// state after each vector operation for the pipeline to drain and the next
// step to be chosen. in_stall_o stays high from the input transfer until the
// result enters the output register, so the block takes no new point while
// it is still working on the last one.
// The result waits in an output register. While the receiver stalls, the
// result is held, and a further finished step waits until it is taken.
// Reset clears the stored vertices and the vertex count, and leaves the
// output channel empty and the block ready.
module gjk_simplex_update #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic                                start_req_i,
  input  logic signed [gsu_pkg::PT_W-1:0]     point_x_i,
  input  logic signed [gsu_pkg::PT_W-1:0]     point_y_i,
  input  logic signed [gsu_pkg::PT_W-1:0]     point_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gsu_pkg::DIR_W-1:0]    dir_x_o,
  output logic signed [gsu_pkg::DIR_W-1:0]    dir_y_o,
  output logic signed [gsu_pkg::DIR_W-1:0]    dir_z_o,
  output logic                                contains_origin_o,
  output logic [2:0]                          vertex_total_o
);

  localparam int OpW  = gsu_pkg::OP_W;
  localparam int DirW = gsu_pkg::DIR_W;
  localparam int AccW = gsu_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DECIDE,
    S_DONE
  } state_e;

  // Vector operations of the sequencer, in the order the cases use them.
  typedef enum logic [4:0] {
    P_AO, P_DIR0, P_AB, P_AC, P_AD, P_ABC, P_T1, P_DOT1, P_DIRAB, P_T2,
    P_DOT2, P_DIRAC, P_DOT3, P_FACE, P_F1, P_D1, P_F2, P_D2, P_F3, P_D3
  } phase_e;

  typedef enum logic [1:0] {
    J_CROSS,
    J_SUB,
    J_MOV,
    J_DOT
  } job_e;

  // How the stored vertices change when the step is committed.
  typedef enum logic [3:0] {
    U_NONE, U_C0, U_C1, U_EAB, U_EAC, U_FPOS, U_FNEG, U_T2, U_T3, U_HIT
  } upd_e;

  typedef struct packed {
    job_e            kind;
    gsu_pkg::vsel_e  u;
    gsu_pkg::vsel_e  v;
    gsu_pkg::vsel_e  w;
    logic            neg;
  } job_t;

  typedef struct packed {
    logic       a_from_v;
    logic [1:0] ca;
    logic       b_one;
    logic [1:0] cb;
    logic       neg;
    logic       clr;
    logic       wr;
    logic [1:0] wc;
    logic       dot;
    logic       last;
  } step_t;

  state_e state_q;
  phase_e ph_q;
  logic [2:0] step_q;
  upd_e upd_q;
  logic hit_q;
  logic mode2d_q;
  logic pos_q;
  logic [2:0] vcnt_q;
  logic out_valid_q;

  logic signed [COORD_BITS-1:0] a_q  [3];
  logic signed [COORD_BITS-1:0] vb_q [3];
  logic signed [COORD_BITS-1:0] vc_q [3];
  logic signed [COORD_BITS-1:0] vd_q [3];

  logic signed [OpW-1:0]  ab_q  [3];
  logic signed [OpW-1:0]  ac_q  [3];
  logic signed [OpW-1:0]  ad_q  [3];
  logic signed [OpW-1:0]  ao_q  [3];
  logic signed [OpW-1:0]  abc_q [3];
  logic signed [OpW-1:0]  t_q   [3];
  logic signed [DirW-1:0] dir_q [3];

  logic signed [DirW-1:0] dir_out_q [3];
  logic                   hit_out_q;
  logic [2:0]             total_out_q;

  job_t                job;
  step_t               stp;
  gsu_pkg::mac_ctrl_t  mac_ctrl;
  gsu_pkg::mac_wb_t    mac_wb;
  logic signed [OpW-1:0] op_a;
  logic signed [OpW-1:0] op_b;

  logic   in_fire;
  logic   out_free;
  logic   cnt_finished;
  logic [2:0] cnt_eff;
  phase_e ph_nxt;
  logic   fin_nxt;
  upd_e   upd_nxt;
  logic   hit_nxt;
  logic [2:0] cnt_new;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // A start request clears the count before this point is used.
  assign cnt_eff      = start_req_i ? 3'd0 : vcnt_q;
  assign cnt_finished = (cnt_eff >= 3'd4) || (func_i && (cnt_eff == 3'd3));

  // Reads one component of a vector register as a multiplier operand.
  function automatic logic signed [OpW-1:0] rd(gsu_pkg::vsel_e s, logic [1:0] k);
    logic signed [OpW-1:0] r;
    r = '0;
    case (s)
      gsu_pkg::V_A:   r = OpW'(a_q[k]);
      gsu_pkg::V_B:   r = OpW'(vb_q[k]);
      gsu_pkg::V_C:   r = OpW'(vc_q[k]);
      gsu_pkg::V_D:   r = OpW'(vd_q[k]);
      gsu_pkg::V_AB:  r = ab_q[k];
      gsu_pkg::V_AC:  r = ac_q[k];
      gsu_pkg::V_AD:  r = ad_q[k];
      gsu_pkg::V_AO:  r = ao_q[k];
      gsu_pkg::V_ABC: r = abc_q[k];
      gsu_pkg::V_T:   r = t_q[k];
      gsu_pkg::V_DIR: r = dir_q[k][OpW-1:0];
      default:        r = '0;
    endcase
    return r;
  endfunction

  // The vector operation of each phase. The edge tests use the triple product
  // identity, so that (AB x ABC) . AO becomes ABC . (AO x AB) and
  // (ABC x AC) . AO becomes ABC . (AC x AO); the double cross products then
  // reuse the same temporary vector T.
  always_comb begin
    job = '{kind: J_MOV, u: gsu_pkg::V_A, v: gsu_pkg::V_A, w: gsu_pkg::V_AO, neg: 1'b1};
    case (ph_q)
      P_AO:    job = '{J_MOV,   gsu_pkg::V_A,   gsu_pkg::V_A,   gsu_pkg::V_AO,  1'b1};
      P_DIR0:  job = '{J_MOV,   gsu_pkg::V_A,   gsu_pkg::V_A,   gsu_pkg::V_DIR, 1'b1};
      P_AB:    job = '{J_SUB,   gsu_pkg::V_B,   gsu_pkg::V_A,   gsu_pkg::V_AB,  1'b0};
      P_AC:    job = '{J_SUB,   gsu_pkg::V_C,   gsu_pkg::V_A,   gsu_pkg::V_AC,  1'b0};
      P_AD:    job = '{J_SUB,   gsu_pkg::V_D,   gsu_pkg::V_A,   gsu_pkg::V_AD,  1'b0};
      P_ABC:   job = '{J_CROSS, gsu_pkg::V_AB,  gsu_pkg::V_AC,  gsu_pkg::V_ABC, 1'b0};
      P_T1:    job = '{J_CROSS, gsu_pkg::V_AO,  gsu_pkg::V_AB,  gsu_pkg::V_T,   1'b0};
      P_DOT1:  job = '{J_DOT,   gsu_pkg::V_ABC, gsu_pkg::V_T,   gsu_pkg::V_T,   1'b0};
      P_DIRAB: job = '{J_CROSS, gsu_pkg::V_AB,  gsu_pkg::V_T,   gsu_pkg::V_DIR, 1'b0};
      P_T2:    job = '{J_CROSS, gsu_pkg::V_AC,  gsu_pkg::V_AO,  gsu_pkg::V_T,   1'b0};
      P_DOT2:  job = '{J_DOT,   gsu_pkg::V_ABC, gsu_pkg::V_T,   gsu_pkg::V_T,   1'b0};
      P_DIRAC: job = '{J_CROSS, gsu_pkg::V_T,   gsu_pkg::V_AC,  gsu_pkg::V_DIR, 1'b0};
      P_DOT3:  job = '{J_DOT,   gsu_pkg::V_ABC, gsu_pkg::V_AO,  gsu_pkg::V_T,   1'b0};
      P_FACE:  job = '{J_MOV,   gsu_pkg::V_ABC, gsu_pkg::V_ABC, gsu_pkg::V_DIR, !pos_q};
      P_F1:    job = '{J_CROSS, gsu_pkg::V_AB,  gsu_pkg::V_AC,  gsu_pkg::V_DIR, 1'b0};
      P_F2:    job = '{J_CROSS, gsu_pkg::V_AD,  gsu_pkg::V_AB,  gsu_pkg::V_DIR, 1'b0};
      P_F3:    job = '{J_CROSS, gsu_pkg::V_AC,  gsu_pkg::V_AD,  gsu_pkg::V_DIR, 1'b0};
      P_D1, P_D2, P_D3:
               job = '{J_DOT,   gsu_pkg::V_AO,  gsu_pkg::V_DIR, gsu_pkg::V_T,   1'b0};
      default: job = '{J_MOV,   gsu_pkg::V_A,   gsu_pkg::V_A,   gsu_pkg::V_AO,  1'b1};
    endcase
  end

  // Expands a vector operation into single multiply-accumulate steps.
  always_comb begin
    stp = '0;
    case (job.kind)
      J_CROSS: begin
        case (step_q)
          3'd0:    stp = '{1'b0, 2'd1, 1'b0, 2'd2, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0};
          3'd1:    stp = '{1'b0, 2'd2, 1'b0, 2'd1, 1'b1, 1'b0, 1'b1, 2'd0, 1'b0, 1'b0};
          3'd2:    stp = '{1'b0, 2'd2, 1'b0, 2'd0, 1'b0, 1'b1, 1'b0, 2'd1, 1'b0, 1'b0};
          3'd3:    stp = '{1'b0, 2'd0, 1'b0, 2'd2, 1'b1, 1'b0, 1'b1, 2'd1, 1'b0, 1'b0};
          3'd4:    stp = '{1'b0, 2'd0, 1'b0, 2'd1, 1'b0, 1'b1, 1'b0, 2'd2, 1'b0, 1'b0};
          default: stp = '{1'b0, 2'd1, 1'b0, 2'd0, 1'b1, 1'b0, 1'b1, 2'd2, 1'b0, 1'b1};
        endcase
      end
      J_SUB: begin
        stp.a_from_v = step_q[0];
        stp.ca       = step_q[2:1];
        stp.b_one    = 1'b1;
        stp.neg      = step_q[0];
        stp.clr      = !step_q[0];
        stp.wr       = step_q[0];
        stp.wc       = step_q[2:1];
        stp.last     = (step_q == 3'd5);
      end
      J_MOV: begin
        stp.ca    = step_q[1:0];
        stp.b_one = 1'b1;
        stp.neg   = job.neg;
        stp.clr   = 1'b1;
        stp.wr    = 1'b1;
        stp.wc    = step_q[1:0];
        stp.last  = (step_q == 3'd2);
      end
      J_DOT: begin
        stp.ca   = step_q[1:0];
        stp.cb   = step_q[1:0];
        stp.clr  = (step_q == 3'd0);
        stp.dot  = (step_q == 3'd2);
        stp.last = (step_q == 3'd2);
      end
      default: stp = '0;
    endcase
  end

  always_comb begin
    op_a = rd(stp.a_from_v ? job.v : job.u, stp.ca);
    op_b = stp.b_one ? OpW'(1) : rd(job.v, stp.cb);
    mac_ctrl.vld  = (state_q == S_RUN);
    mac_ctrl.clr  = stp.clr;
    mac_ctrl.neg  = stp.neg;
    mac_ctrl.wr   = stp.wr;
    mac_ctrl.dot  = stp.dot;
    mac_ctrl.comp = stp.wc;
    mac_ctrl.dest = job.w;
  end

  gsu_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .wb_o   (mac_wb)
  );

  // Chooses the next operation once the previous one has been written back.
  always_comb begin
    ph_nxt  = ph_q;
    fin_nxt = 1'b0;
    upd_nxt = U_NONE;
    hit_nxt = 1'b0;
    case (ph_q)
      P_AO:    ph_nxt = (vcnt_q == 3'd0) ? P_DIR0 : P_AB;
      P_DIR0: begin
        fin_nxt = 1'b1;
        upd_nxt = U_C0;
      end
      P_AB:    ph_nxt = (vcnt_q == 3'd1) ? P_T1 : P_AC;
      P_AC:    ph_nxt = (vcnt_q == 3'd2) ? P_ABC : P_AD;
      P_AD:    ph_nxt = P_F1;
      P_ABC:   ph_nxt = P_T1;
      P_T1:    ph_nxt = (vcnt_q == 3'd1) ? P_DIRAB : P_DOT1;
      P_DOT1:  ph_nxt = pos_q ? P_DIRAB : P_T2;
      P_DIRAB: begin
        fin_nxt = 1'b1;
        upd_nxt = (vcnt_q == 3'd1) ? U_C1 : U_EAB;
      end
      P_T2:    ph_nxt = P_DOT2;
      P_DOT2:  ph_nxt = pos_q ? P_DIRAC : P_DOT3;
      P_DIRAC: begin
        fin_nxt = 1'b1;
        upd_nxt = U_EAC;
      end
      P_DOT3:  ph_nxt = P_FACE;
      P_FACE: begin
        fin_nxt = 1'b1;
        upd_nxt = pos_q ? U_FPOS : U_FNEG;
        hit_nxt = mode2d_q;
      end
      P_F1:    ph_nxt = P_D1;
      P_F2:    ph_nxt = P_D2;
      P_F3:    ph_nxt = P_D3;
      P_D1: begin
        ph_nxt  = P_F2;
        fin_nxt = pos_q;
        upd_nxt = U_FPOS;
      end
      P_D2: begin
        ph_nxt  = P_F3;
        fin_nxt = pos_q;
        upd_nxt = U_T2;
      end
      P_D3: begin
        fin_nxt = 1'b1;
        upd_nxt = pos_q ? U_T3 : U_HIT;
        hit_nxt = !pos_q;
      end
      default: ph_nxt = P_AO;
    endcase
  end

  always_comb begin
    case (upd_q)
      U_C0:                      cnt_new = 3'd1;
      U_C1, U_EAB, U_EAC:        cnt_new = 3'd2;
      U_FPOS, U_FNEG, U_T2, U_T3: cnt_new = 3'd3;
      U_HIT:                     cnt_new = 3'd4;
      default:                   cnt_new = vcnt_q;
    endcase
  end

  // Sequencer, stored simplex and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= P_AO;
      step_q      <= '0;
      upd_q       <= U_NONE;
      hit_q       <= 1'b0;
      mode2d_q    <= 1'b0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vb_q[i] <= '0;
        vc_q[i] <= '0;
        vd_q[i] <= '0;
      end
    end else begin
      // A finished step fills the output register as soon as it is free.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            mode2d_q <= func_i;
            vcnt_q   <= cnt_eff;
            ph_q     <= P_AO;
            step_q   <= '0;
            hit_q    <= 1'b0;
            upd_q    <= U_NONE;
            // A finished simplex ignores the point and gives a zero direction.
            state_q  <= cnt_finished ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (stp.last) begin
            step_q  <= '0;
            state_q <= S_DRAIN;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_DRAIN: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (fin_nxt) begin
            upd_q   <= upd_nxt;
            hit_q   <= hit_nxt;
            state_q <= S_DONE;
          end else begin
            ph_q    <= ph_nxt;
            state_q <= S_RUN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            vcnt_q      <= cnt_new;
            state_q     <= S_IDLE;
            case (upd_q)
              U_C0, U_EAC, U_T3: begin
                vb_q <= a_q;
              end
              U_C1: begin
                vc_q <= vb_q;
                vb_q <= a_q;
              end
              U_EAB: begin
                vc_q <= a_q;
              end
              U_FPOS: begin
                vd_q <= vc_q;
                vc_q <= vb_q;
                vb_q <= a_q;
              end
              U_FNEG: begin
                vd_q <= vb_q;
                vb_q <= a_q;
              end
              U_T2: begin
                vc_q <= vd_q;
                vd_q <= vb_q;
                vb_q <= a_q;
              end
              default: begin
              end
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Operand capture, write-back of the shared unit and result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q[0] <= point_x_i[COORD_BITS-1:0];
      a_q[1] <= point_y_i[COORD_BITS-1:0];
      a_q[2] <= point_z_i[COORD_BITS-1:0];
    end
    if (mac_wb.dot) begin
      pos_q <= !mac_wb.val[AccW-1] && (mac_wb.val != '0);
    end
    if (mac_wb.wr) begin
      case (mac_wb.dest)
        gsu_pkg::V_AB:  ab_q[mac_wb.comp]  <= mac_wb.val[OpW-1:0];
        gsu_pkg::V_AC:  ac_q[mac_wb.comp]  <= mac_wb.val[OpW-1:0];
        gsu_pkg::V_AD:  ad_q[mac_wb.comp]  <= mac_wb.val[OpW-1:0];
        gsu_pkg::V_AO:  ao_q[mac_wb.comp]  <= mac_wb.val[OpW-1:0];
        gsu_pkg::V_ABC: abc_q[mac_wb.comp] <= mac_wb.val[OpW-1:0];
        gsu_pkg::V_T:   t_q[mac_wb.comp]   <= mac_wb.val[OpW-1:0];
        gsu_pkg::V_DIR: dir_q[mac_wb.comp] <= mac_wb.val[DirW-1:0];
        default: begin
        end
      endcase
    end
    if (state_q == S_DONE && out_free) begin
      for (int i = 0; i < 3; i++) begin
        dir_out_q[i] <= (upd_q == U_NONE) ? '0 : dir_q[i];
      end
      hit_out_q   <= hit_q;
      total_out_q <= cnt_new;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign dir_x_o           = dir_out_q[0];
  assign dir_y_o           = dir_out_q[1];
  assign dir_z_o           = dir_out_q[2];
  assign contains_origin_o = hit_out_q;
  assign vertex_total_o    = total_out_q;

  // The simplex never holds more than four vertices.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= 3'd4)
    else $error("vertex count above four");

  // The shared unit only writes back while an operation is in flight.
  a_wb_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mac_wb.wr || mac_wb.dot) |-> (state_q == S_RUN || state_q == S_DRAIN))
    else $error("write-back outside an operation");

  // An accepted point starts work or goes straight to the result stage.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_RUN || state_q == S_DONE))
    else $error("accepted point not taken up");

  // Enclosure is only reported for a triangle or a tetrahedron.
  a_hit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && contains_origin_o) |-> (vertex_total_o == 3'd3 || vertex_total_o == 3'd4))
    else $error("enclosure flagged with too few vertices");

endmodule
